@@ rtl/core/disparity_to_point_reprojection_core_macros.svh @@
// Assertion helpers for the reprojection core.
`ifndef DISPARITY_TO_POINT_REPROJECTION_CORE_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTION_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define DTPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtpr assertion failed");
`define DTPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtpr assertion failed");
`else
`define DTPR_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/dtpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtpr_pkg;

   // image geometry and sampling grid (stride is a power of two)
   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int SAMPLE_STRIDE = 1;
   localparam logic [10:0] STRIDE_MASK = 11'(SAMPLE_STRIDE - 1);

   // one pixel of disparity, in sixteenths
   localparam logic signed [15:0] MIN_DISP_RAW = 16'sd16;

   // datapath widths
   localparam int PROD_W    = 48;   // one matrix term at scale 2^-20
   localparam int HOM_W     = 50;   // homogeneous component sum
   localparam int MAG_W     = 50;   // magnitude of a component
   localparam int FRAC_BITS = 16;
   localparam int DIV_STEPS = 33;   // quotient bits 32..0
   localparam int PRE_SHIFT = DIV_STEPS - FRAC_BITS;

   // pipeline stage numbering
   localparam int ST_MUL  = 0;
   localparam int ST_PAIR = 1;
   localparam int ST_SUM  = 2;
   localparam int ST_PREP = 3;
   localparam int ST_DIV0 = 4;
   localparam int ST_SAT  = ST_DIV0 + DIV_STEPS;
   localparam int ST_SQ   = ST_SAT + 1;
   localparam int ST_OUT  = ST_SQ + 1;
   localparam int NSTAGE  = ST_OUT + 1;

   typedef enum logic [2:0] {
      REJ_NONE     = 3'd0,
      REJ_STRIDE   = 3'd1,
      REJ_LOW_DISP = 3'd2,
      REJ_DIVISOR  = 3'd3,
      REJ_NEAR     = 3'd4
   } reject_type;

   // one divider lane in flight
   typedef struct packed {
      logic [MAG_W-1:0]     rem;
      logic [DIV_STEPS-1:0] low;
      logic [MAG_W-1:0]     den;
      logic                 pre_ovf;
      logic                 neg;
      logic                 num_zero;
   } div_lane_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               ovf;
   } div_res_type;

endpackage
`default_nettype wire

@@ rtl/core/dtpr_div_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtpr_div_lane (
   input  logic                            clock,
   input  logic [dtpr_pkg::DIV_STEPS-1:0]  step_en,
   input  dtpr_pkg::div_lane_type          lane_in,
   output dtpr_pkg::div_res_type           res_out
);
   import dtpr_pkg::*;

   div_lane_type         stage_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff   [DIV_STEPS];

   // one restoring step per stage
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      div_lane_type         src;
      logic [DIV_STEPS-1:0] src_quo;
      div_lane_type         stage_in;
      logic [DIV_STEPS-1:0] quo_in;
      logic [MAG_W:0]       trial;
      logic                 take;

      if (s == 0) begin : g_first
         assign src     = lane_in;
         assign src_quo = '0;
      end else begin : g_rest
         assign src     = stage_ff[s-1];
         assign src_quo = quo_ff[s-1];
      end

      always_comb begin
         trial = {src.rem, src.low[DIV_STEPS-1]};
         take  = trial >= {1'b0, src.den};
         stage_in     = src;
         stage_in.rem = take ? MAG_W'(trial - {1'b0, src.den}) : trial[MAG_W-1:0];
         stage_in.low = {src.low[DIV_STEPS-2:0], 1'b0};
         quo_in       = {src_quo[DIV_STEPS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (step_en[s]) begin
            stage_ff[s] <= stage_in;
            quo_ff[s]   <= quo_in;
         end
      end
   end

   // sign, saturation and zero-numerator handling
   logic [DIV_STEPS-1:0] lim;
   logic [DIV_STEPS-1:0] mag;
   logic                 over;
   div_lane_type         last;

   always_comb begin
      last = stage_ff[DIV_STEPS-1];
      lim  = last.neg ? DIV_STEPS'(33'h0_8000_0000) : DIV_STEPS'(33'h0_7FFF_FFFF);
      over = last.pre_ovf || (quo_ff[DIV_STEPS-1] > lim);
      mag  = over ? lim : quo_ff[DIV_STEPS-1];
      res_out.ovf = over;
      if (last.num_zero) begin
         res_out.value = '0;
      end else if (last.neg) begin
         res_out.value = 32'(-mag);
      end else begin
         res_out.value = 32'(mag);
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/disparity_to_point_reprojection_core.sv @@
// Disparity-to-point reprojection core.
// Input channel (req_*): one disparity pixel per transaction, taken when
// req_valid is high and req_stall is low. Result channel (rsp_*): one point
// per pixel, in order, with kept flag, reject code and the frame_end echo.
// Configuration (csr_*): eight 64-bit words holding the 4x4 Q matrix; the user
// must write them only while the core is empty, which the core does not enforce.
// Stage order: products, pair sums, sums, prep, divider, saturation, squares,
// output. Throughput: one pixel per cycle while rsp_stall is low; the 33-stage
// restoring divider (one quotient bit per stage, three lanes) sets the depth.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles close up and a new pixel is still taken while a result waits at
// the output. With the pipe full and rsp_stall high, req_stall goes high.
// Reset (synchronous) empties the pipe and clears the matrix to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "disparity_to_point_reprojection_core_macros.svh"
module disparity_to_point_reprojection_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [10:0]        req_pixel_col,
   input  logic [10:0]        req_pixel_row,
   input  logic signed [15:0] req_disparity_raw,
   input  logic               req_frame_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic               rsp_point_kept,
   output logic [2:0]         rsp_reject_code,
   output logic               rsp_frame_done,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import dtpr_pkg::*;

   // matrix registers
   logic [63:0] q_regs_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) q_regs_ff[i] <= '0;
      end else if (csr_write_en) begin
         q_regs_ff[csr_index] <= csr_wdata;
      end
   end

   logic signed [31:0] q_e [4][4];
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         q_e[r][0] = $signed(q_regs_ff[r*2][63:32]);
         q_e[r][1] = $signed(q_regs_ff[r*2][31:0]);
         q_e[r][2] = $signed(q_regs_ff[r*2+1][63:32]);
         q_e[r][3] = $signed(q_regs_ff[r*2+1][31:0]);
      end
   end

   // stage enables: a stage loads when empty or when its successor loads
   logic [NSTAGE:0]   en;
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;

   assign en[NSTAGE] = !rsp_stall;
   for (genvar k = 0; k < NSTAGE; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign req_stall = !en[ST_MUL];

   always_comb begin
      vld_in[0] = req_valid;
      for (int k = 1; k < NSTAGE; k++) vld_in[k] = vld_ff[k-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   // early reject code and frame marker travel alongside
   reject_type code_ff  [NSTAGE];
   reject_type code_in  [NSTAGE];
   logic       frame_ff [NSTAGE];
   logic       frame_in [NSTAGE];
   logic       off_grid;
   logic       near;
   logic       far_any;
   logic [33:0] sq_sum;

   logic        ovf_ff;
   logic        sq_ovf_ff;

   always_comb begin
      off_grid = (32'(req_pixel_col) >= MAX_WIDTH) || (32'(req_pixel_row) >= MAX_HEIGHT)
              || ((req_pixel_col & STRIDE_MASK) != '0)
              || ((req_pixel_row & STRIDE_MASK) != '0);
      if (off_grid) begin
         code_in[0] = REJ_STRIDE;
      end else if (req_disparity_raw < MIN_DISP_RAW) begin
         code_in[0] = REJ_LOW_DISP;
      end else begin
         code_in[0] = REJ_NONE;
      end
      frame_in[0] = req_frame_end;
      for (int k = 1; k < NSTAGE; k++) begin
         code_in[k]  = code_ff[k-1];
         frame_in[k] = frame_ff[k-1];
      end
      // final decision at the output stage
      if (code_ff[ST_SQ] == REJ_NONE) begin
         if (sq_ovf_ff) begin
            code_in[ST_OUT] = REJ_DIVISOR;
         end else if (near) begin
            code_in[ST_OUT] = REJ_NEAR;
         end else begin
            code_in[ST_OUT] = REJ_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGE; k++) begin
         if (en[k]) begin
            code_ff[k]  <= code_in[k];
            frame_ff[k] <= frame_in[k];
         end
      end
   end

   // stage 0: the sixteen matrix products at scale 2^-20
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PROD_W-1:0] prod_in [4][4];
   logic signed [11:0]       col_s;
   logic signed [11:0]       row_s;

   always_comb begin
      col_s = $signed({1'b0, req_pixel_col});
      row_s = $signed({1'b0, req_pixel_row});
      for (int r = 0; r < 4; r++) begin
         prod_in[r][0] = (q_e[r][0] * col_s) <<< 4;
         prod_in[r][1] = (q_e[r][1] * row_s) <<< 4;
         prod_in[r][2] = q_e[r][2] * req_disparity_raw;
         prod_in[r][3] = PROD_W'(q_e[r][3]) <<< 4;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) prod_ff <= prod_in;
   end

   // stage 1: pair sums
   logic signed [HOM_W-1:0] pair_ff [4][2];
   always_ff @(posedge clock) begin
      if (en[ST_PAIR]) begin
         for (int r = 0; r < 4; r++) begin
            pair_ff[r][0] <= HOM_W'(prod_ff[r][0]) + HOM_W'(prod_ff[r][1]);
            pair_ff[r][1] <= HOM_W'(prod_ff[r][2]) + HOM_W'(prod_ff[r][3]);
         end
      end
   end

   // stage 2: homogeneous components
   logic signed [HOM_W-1:0] h_ff [4];
   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         for (int r = 0; r < 4; r++) h_ff[r] <= pair_ff[r][0] + pair_ff[r][1];
      end
   end

   // stage 3: magnitudes, signs and range pre-check for the dividers
   div_lane_type     lane_ff [3];
   div_lane_type     lane_in [3];
   logic [MAG_W-1:0] num_mag [3];
   logic [MAG_W-1:0] den_mag;

   always_comb begin
      den_mag = h_ff[3] < 0 ? MAG_W'(-h_ff[3]) : MAG_W'(h_ff[3]);
      for (int i = 0; i < 3; i++) begin
         num_mag[i] = h_ff[i] < 0 ? MAG_W'(-h_ff[i]) : MAG_W'(h_ff[i]);
         lane_in[i].rem      = num_mag[i] >> PRE_SHIFT;
         lane_in[i].low      = DIV_STEPS'(num_mag[i][PRE_SHIFT-1:0]) << FRAC_BITS;
         lane_in[i].den      = den_mag;
         lane_in[i].pre_ovf  = (num_mag[i] >> PRE_SHIFT) >= den_mag;
         lane_in[i].neg      = (h_ff[i] < 0) != (h_ff[3] < 0);
         lane_in[i].num_zero = h_ff[i] == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PREP]) lane_ff <= lane_in;
   end

   // divider lanes, one quotient bit per stage
   div_res_type div_res [3];
   for (genvar i = 0; i < 3; i++) begin : g_div
      dtpr_div_lane u_div (
         .clock   (clock),
         .step_en (en[ST_DIV0 +: DIV_STEPS]),
         .lane_in (lane_ff[i]),
         .res_out (div_res[i])
      );
   end

   // saturated quotients
   logic signed [31:0] pt_ff [3];
   always_ff @(posedge clock) begin
      if (en[ST_SAT]) begin
         for (int i = 0; i < 3; i++) pt_ff[i] <= div_res[i].value;
         ovf_ff <= div_res[0].ovf || div_res[1].ovf || div_res[2].ovf;
      end
   end

   // squares for the near test
   logic signed [31:0] sq_pt_ff [3];
   logic [31:0]        sq_ff    [3];
   logic [2:0]         far_ff;
   logic [31:0]        pt_mag   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt_mag[i] = pt_ff[i] < 0 ? 32'(-pt_ff[i]) : 32'(pt_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQ]) begin
         for (int i = 0; i < 3; i++) begin
            sq_pt_ff[i] <= pt_ff[i];
            sq_ff[i]    <= pt_mag[i][15:0] * pt_mag[i][15:0];
            far_ff[i]   <= pt_mag[i][31:16] != '0;
         end
         sq_ovf_ff <= ovf_ff;
      end
   end

   always_comb begin
      far_any = |far_ff;
      sq_sum  = 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
      near    = !far_any && (sq_sum[33:32] == 2'b00);
   end

   // output register
   logic signed [31:0] out_pt_ff [3];
   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         for (int i = 0; i < 3; i++) begin
            out_pt_ff[i] <= (code_ff[ST_SQ] == REJ_STRIDE || code_ff[ST_SQ] == REJ_LOW_DISP)
                            ? '0 : sq_pt_ff[i];
         end
      end
   end

   assign rsp_valid       = vld_ff[ST_OUT];
   assign rsp_point_x     = out_pt_ff[0];
   assign rsp_point_y     = out_pt_ff[1];
   assign rsp_point_z     = out_pt_ff[2];
   assign rsp_reject_code = code_ff[ST_OUT];
   assign rsp_point_kept  = code_ff[ST_OUT] == REJ_NONE;
   assign rsp_frame_done  = frame_ff[ST_OUT];

   // checks
   `DTPR_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, vld_ff[ST_MUL])
   `DTPR_ASSERT_NEXT(a_held_result, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `DTPR_ASSERT_IMP(a_early_reject_zero, clock, reset,
      rsp_valid && (code_ff[ST_OUT] == REJ_STRIDE || code_ff[ST_OUT] == REJ_LOW_DISP),
      rsp_point_x == 0 && rsp_point_y == 0 && rsp_point_z == 0)

endmodule
`default_nettype wire
